### rtl/gctp_pkg.sv
// Package: shared types and codes for the graphics command token parser.
`default_nettype none

package gctp_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_NUMBER  = 3'd1,
        PH_OPCODE  = 3'd2,
        PH_STRLEN  = 3'd3,
        PH_CHARS   = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    // Token kinds
    localparam logic [2:0] KIND_NUMBER = 3'd0;
    localparam logic [2:0] KIND_OPCODE = 3'd1;
    localparam logic [2:0] KIND_CHAR   = 3'd2;
    localparam logic [2:0] KIND_EMPTY  = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_SIZE  = 2'd0;
    localparam logic [1:0] ERR_TYPE  = 2'd1;
    localparam logic [1:0] ERR_FMT   = 2'd2;
    localparam logic [1:0] ERR_TRUNC = 2'd3;

    // Header low-bit token classes
    localparam logic [1:0] HDR_NUMBER  = 2'd0;
    localparam logic [1:0] HDR_COMMAND = 2'd1;
    localparam logic [1:0] HDR_OBJECT  = 2'd2;

    // Object type of a string
    localparam logic [4:0] OBJ_STRING = 5'd1;

    // Number size codes, and the one that is invalid
    localparam logic [1:0] NUM_SIZE_BAD  = 2'd3;
    localparam logic [1:0] NUM_SIZE_WORD = 2'd2;
    localparam logic [1:0] NUM_SIZE_HALF = 2'd1;
    localparam logic [1:0] NUM_SIZE_BYTE = 2'd0;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_in_buffer;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [31:0] value;
        logic        string_last;
        logic [1:0]  error_code;
    } out_item_t;

    // Handshake control from the parse stage to the neighbor stages
    typedef struct packed {
        logic consume;
        logic load;
    } step_ctl_t;

endpackage

`default_nettype wire

### rtl/gctp_in_stage.sv
// Input register stage: holds one accepted byte until the parser consumes it.
`default_nettype none

module gctp_in_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire gctp_pkg::in_item_t s_item,
    input  wire gctp_pkg::step_ctl_t ctl,
    output logic                    hold_valid,
    output gctp_pkg::in_item_t      hold_item
);

    logic               valid_reg;
    logic               valid_next;
    gctp_pkg::in_item_t item_reg;

    // Take a new transfer when empty or when the held byte leaves this cycle
    assign s_ready = !valid_reg || ctl.consume;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (ctl.consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

`default_nettype wire

### rtl/gctp_parse.sv
// Parse stage: token state registers and the per-byte decode logic.
`default_nettype none

module gctp_parse (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_data,
    input  wire logic                hold_valid,
    input  wire gctp_pkg::in_item_t  hold_item,
    input  wire logic                out_free,
    output gctp_pkg::step_ctl_t      ctl,
    output gctp_pkg::out_item_t      res_item
);

    gctp_pkg::phase_t phase_reg,  phase_next;
    logic [2:0]       bytes_left_reg, bytes_left_next;
    logic             num_signed_reg, num_signed_next;
    logic [1:0]       num_size_reg,   num_size_next;
    logic [31:0]      acc_reg,        acc_next;
    logic [3:0]       op_low_reg,     op_low_next;
    logic [7:0]       chars_left_reg, chars_left_next;
    logic [7:0]       first_byte_reg, first_byte_next;
    logic             char_half_reg,  char_half_next;
    logic             big_endian_reg;

    logic             emit;
    logic             step;
    logic [7:0]       b;
    logic             last;
    logic [31:0]      acc_shift;
    logic [2:0]       bytes_dec;
    logic [7:0]       chars_dec;
    logic [15:0]      char_code;

    assign b    = hold_item.byte_in;
    assign last = hold_item.last_in_buffer;

    // Advance when a byte is held and its result, if any, has room
    assign step        = hold_valid && (!emit || out_free);
    assign ctl.consume = step;
    assign ctl.load    = step && emit;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg <= 1'b0;
        end else if (cfg_valid) begin
            big_endian_reg <= cfg_data;
        end
    end

    // Decode one byte against the current phase
    always_comb begin
        acc_shift = {acc_reg[23:0], b};
        bytes_dec = bytes_left_reg - 3'd1;
        chars_dec = chars_left_reg - 8'd1;
        char_code = big_endian_reg ? {first_byte_reg, b} : {b, first_byte_reg};

        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        num_signed_next = num_signed_reg;
        num_size_next   = num_size_reg;
        acc_next        = acc_reg;
        op_low_next     = op_low_reg;
        chars_left_next = chars_left_reg;
        first_byte_next = first_byte_reg;
        char_half_next  = char_half_reg;

        emit     = 1'b0;
        res_item = '0;

        case (phase_reg)
            gctp_pkg::PH_NUMBER: begin
                acc_next        = acc_shift;
                bytes_left_next = bytes_dec;
                if (bytes_dec != 3'd0) begin
                    if (last) begin
                        emit                = 1'b1;
                        res_item.token_kind = gctp_pkg::KIND_ERROR;
                        res_item.error_code = gctp_pkg::ERR_TRUNC;
                        phase_next          = gctp_pkg::PH_HEADER;
                    end
                end else begin
                    emit                = 1'b1;
                    phase_next          = gctp_pkg::PH_HEADER;
                    res_item.token_kind = gctp_pkg::KIND_NUMBER;
                    res_item.value      = acc_shift;
                    // Sign-extend the short signed forms
                    if (num_signed_reg) begin
                        if (num_size_reg == gctp_pkg::NUM_SIZE_BYTE && acc_shift[7]) begin
                            res_item.value = acc_shift | 32'hFFFF_FF00;
                        end else if (num_size_reg == gctp_pkg::NUM_SIZE_HALF
                                     && acc_shift[15]) begin
                            res_item.value = acc_shift | 32'hFFFF_0000;
                        end
                    end
                end
            end

            gctp_pkg::PH_OPCODE: begin
                emit                = 1'b1;
                phase_next          = gctp_pkg::PH_HEADER;
                res_item.token_kind = gctp_pkg::KIND_OPCODE;
                res_item.value      = {20'd0, b, op_low_reg};
            end

            gctp_pkg::PH_STRLEN: begin
                if (b == 8'd0) begin
                    emit                = 1'b1;
                    phase_next          = gctp_pkg::PH_HEADER;
                    res_item.token_kind = gctp_pkg::KIND_EMPTY;
                end else if (last) begin
                    emit                = 1'b1;
                    phase_next          = gctp_pkg::PH_HEADER;
                    res_item.token_kind = gctp_pkg::KIND_ERROR;
                    res_item.error_code = gctp_pkg::ERR_TRUNC;
                end else begin
                    chars_left_next = b;
                    char_half_next  = 1'b0;
                    phase_next      = gctp_pkg::PH_CHARS;
                end
            end

            gctp_pkg::PH_CHARS: begin
                if (!char_half_reg) begin
                    if (last) begin
                        emit                = 1'b1;
                        phase_next          = gctp_pkg::PH_HEADER;
                        res_item.token_kind = gctp_pkg::KIND_ERROR;
                        res_item.error_code = gctp_pkg::ERR_TRUNC;
                    end else begin
                        first_byte_next = b;
                        char_half_next  = 1'b1;
                    end
                end else begin
                    char_half_next  = 1'b0;
                    chars_left_next = chars_dec;
                    emit            = 1'b1;
                    if (chars_dec != 8'd0 && last) begin
                        phase_next          = gctp_pkg::PH_HEADER;
                        res_item.token_kind = gctp_pkg::KIND_ERROR;
                        res_item.error_code = gctp_pkg::ERR_TRUNC;
                    end else begin
                        res_item.token_kind = gctp_pkg::KIND_CHAR;
                        res_item.value      = {16'd0, char_code};
                        if (chars_dec == 8'd0) begin
                            phase_next           = gctp_pkg::PH_HEADER;
                            res_item.string_last = 1'b1;
                        end
                    end
                end
            end

            gctp_pkg::PH_DISCARD: begin
                // Drop the rest of the write after an error
                if (last) begin
                    phase_next = gctp_pkg::PH_HEADER;
                end
            end

            default: begin
                // Header byte
                case (b[1:0])
                    gctp_pkg::HDR_NUMBER: begin
                        if (b[7:6] == gctp_pkg::NUM_SIZE_BAD) begin
                            emit                = 1'b1;
                            res_item.token_kind = gctp_pkg::KIND_ERROR;
                            res_item.error_code = gctp_pkg::ERR_SIZE;
                            phase_next = last ? gctp_pkg::PH_HEADER : gctp_pkg::PH_DISCARD;
                        end else if (last) begin
                            emit                = 1'b1;
                            res_item.token_kind = gctp_pkg::KIND_ERROR;
                            res_item.error_code = gctp_pkg::ERR_TRUNC;
                            phase_next          = gctp_pkg::PH_HEADER;
                        end else begin
                            num_signed_next = (b[5:3] != 3'd0);
                            num_size_next   = b[7:6];
                            bytes_left_next = (b[7:6] == gctp_pkg::NUM_SIZE_WORD) ? 3'd4
                                            : {1'b0, b[7:6]} + 3'd1;
                            acc_next        = 32'd0;
                            phase_next      = gctp_pkg::PH_NUMBER;
                        end
                    end
                    gctp_pkg::HDR_COMMAND: begin
                        if (last) begin
                            emit                = 1'b1;
                            res_item.token_kind = gctp_pkg::KIND_ERROR;
                            res_item.error_code = gctp_pkg::ERR_TRUNC;
                            phase_next          = gctp_pkg::PH_HEADER;
                        end else begin
                            op_low_next = b[7:4];
                            phase_next  = gctp_pkg::PH_OPCODE;
                        end
                    end
                    gctp_pkg::HDR_OBJECT: begin
                        if (b[7:3] != gctp_pkg::OBJ_STRING) begin
                            emit                = 1'b1;
                            res_item.token_kind = gctp_pkg::KIND_ERROR;
                            res_item.error_code = gctp_pkg::ERR_TYPE;
                            phase_next = last ? gctp_pkg::PH_HEADER : gctp_pkg::PH_DISCARD;
                        end else if (last) begin
                            emit                = 1'b1;
                            res_item.token_kind = gctp_pkg::KIND_ERROR;
                            res_item.error_code = gctp_pkg::ERR_TRUNC;
                            phase_next          = gctp_pkg::PH_HEADER;
                        end else begin
                            phase_next = gctp_pkg::PH_STRLEN;
                        end
                    end
                    default: begin
                        emit                = 1'b1;
                        res_item.token_kind = gctp_pkg::KIND_ERROR;
                        res_item.error_code = gctp_pkg::ERR_FMT;
                        phase_next = last ? gctp_pkg::PH_HEADER : gctp_pkg::PH_DISCARD;
                    end
                endcase
            end
        endcase
    end

    // Phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= gctp_pkg::PH_HEADER;
        end else if (step) begin
            phase_reg <= phase_next;
        end
    end

    // Token working registers, written before every read
    always_ff @(posedge aclk) begin
        if (step) begin
            bytes_left_reg <= bytes_left_next;
            num_signed_reg <= num_signed_next;
            num_size_reg   <= num_size_next;
            acc_reg        <= acc_next;
            op_low_reg     <= op_low_next;
            chars_left_reg <= chars_left_next;
            first_byte_reg <= first_byte_next;
            char_half_reg  <= char_half_next;
        end
    end

endmodule

`default_nettype wire

### rtl/gctp_out_stage.sv
// Result register stage: holds one token until the receiver takes it.
`default_nettype none

module gctp_out_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire gctp_pkg::step_ctl_t ctl,
    input  wire gctp_pkg::out_item_t res_item,
    output logic                     out_free,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output gctp_pkg::out_item_t      m_item
);

    logic                valid_reg;
    logic                valid_next;
    gctp_pkg::out_item_t item_reg;

    // Room for a new token when empty or when the held one leaves now
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (ctl.load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload from the parse stage
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            item_reg <= res_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

`default_nettype wire

### rtl/graphics_command_token_parser.sv
// Top level: graphics command token parser, input stage, parse stage, result stage.
//
// Usage:
//   s_valid/s_ready/s_item carry the command stream one byte per transfer,
//   with last_in_buffer marking the final byte of one write.
//   m_valid/m_ready/m_item carry tokens: numbers, opcodes, string characters,
//   empty strings and errors. A byte gives at most one token.
//   cfg_valid/cfg_ready/cfg_data write the character byte order bit;
//   cfg_ready is always high. Write it only while the parser is idle.
// Path: the last byte of a token sits in the input register while the decode
//   logic feeds the result register, which drives m_valid and m_item.
// Throughput: one byte per cycle; the input register, the parse state and
//   the result register each move every cycle while the receiver keeps up.
// Stall: when m_ready is low with a token waiting, a byte that makes no token
//   still goes through; a byte that makes a token waits in the input register
//   and s_ready drops until the result register frees up.
// Reset: synchronous active-low aresetn empties both registers, returns the
//   parser to expecting a header and clears the byte order bit.
`default_nettype none

module graphics_command_token_parser (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire gctp_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output gctp_pkg::out_item_t      m_item
);

    gctp_pkg::step_ctl_t ctl;
    gctp_pkg::in_item_t  hold_item;
    gctp_pkg::out_item_t res_item;
    logic                hold_valid;
    logic                out_free;

    assign cfg_ready = 1'b1;

    gctp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .ctl        (ctl),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    gctp_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .hold_valid (hold_valid),
        .hold_item  (hold_item),
        .out_free   (out_free),
        .ctl        (ctl),
        .res_item   (res_item)
    );

    gctp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .res_item (res_item),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

`default_nettype wire
